FILE: sv/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LRDQ_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("lrdq assertion failed");

// next-cycle implication, disabled while reset is asserted
`define LRDQ_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("lrdq assertion failed");

`endif

FILE: sv/lrdq_pkg.sv
// ----------------------------------------------------------------------------
// lrdq_pkg
// Types, codes and defaults of the descriptor ring queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrdq_pkg;

	localparam int unsigned DEF_MAX_SLOTS = 4096;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 23;
	localparam int unsigned CFG_SLOT_W = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PEER_CLOSED   = 2'd2;

	localparam logic [12:0] RST_SLOT_COUNT    = 13'd256;
	localparam logic [22:0] RST_PAYLOAD_LIMIT = 23'd4096;

	localparam logic [2:0] ACT_PUBLISH = 3'd0;
	localparam logic [2:0] ACT_BORROW  = 3'd1;
	localparam logic [2:0] ACT_COMMIT  = 3'd2;
	localparam logic [2:0] ACT_TAKE    = 3'd3;
	localparam logic [2:0] ACT_TAIL    = 3'd4;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_EMPTY   = 3'd1;
	localparam logic [2:0] ST_INVALID = 3'd2;
	localparam logic [2:0] ST_CLOSED  = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;
	localparam logic [2:0] ST_DROPPED = 3'd5;
	localparam logic [2:0] ST_STALE   = 3'd6;

	typedef struct packed {
		logic [2:0]  action;
		logic [22:0] data_len;
		logic        reliable_mode;
		logic [63:0] stamp_time;
		logic [11:0] target_slot;
		logic [63:0] read_cursor;
		logic [63:0] tail_value;
	} lrdq_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [11:0] slot_index;
		logic [63:0] seq_number;
		logic [22:0] slot_size;
		logic [63:0] slot_time;
		logic [63:0] drop_count;
		logic        notify;
	} lrdq_out_t;

	typedef struct packed {
		logic [63:0] seq;
		logic [22:0] len;
		logic [63:0] stamp;
	} slot_meta_t;

endpackage

`default_nettype wire

FILE: sv/lrdq_ram.sv
// ----------------------------------------------------------------------------
// lrdq_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrdq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/lrdq_core.sv
// ----------------------------------------------------------------------------
// lrdq_core
// Request decode, ring counters and result formation for one request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrdq_core import lrdq_pkg::*; #(
	parameter int unsigned IW = $clog2(DEF_MAX_SLOTS)
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire lrdq_in_t    req,
	input  wire logic        advance,
	input  wire logic [IW-1:0] mask,
	input  wire logic [22:0] payload_limit,
	input  wire logic        peer_closed,
	input  wire slot_meta_t  meta,
	output lrdq_out_t        rsp,
	output logic             wr_en,
	output logic [IW-1:0]    wr_addr,
	output slot_meta_t       wr_data
);

	logic [63:0] head_q, tail_q, drops_q;
	logic [63:0] head_d, tail_d, drops_d;
	logic        wr_req;
	logic        room;
	logic        oversize;
	logic [IW-1:0] head_idx, tgt_idx, cur_idx;

	assign room     = (head_q - tail_q) <= (64'(mask) - 64'd1);
	assign oversize = req.data_len > payload_limit;
	assign head_idx = head_q[IW-1:0] & mask;
	assign tgt_idx  = IW'(req.target_slot) & mask;
	assign cur_idx  = req.read_cursor[IW-1:0] & mask;

	always_comb begin
		rsp     = '0;
		wr_req  = 1'b0;
		wr_addr = head_idx;
		wr_data = '{seq: head_q, len: req.data_len, stamp: req.stamp_time};
		head_d  = head_q;
		tail_d  = tail_q;
		drops_d = drops_q;
		case (req.action)
			ACT_PUBLISH, ACT_BORROW: begin
				if (req.action == ACT_PUBLISH && oversize) begin
					rsp.status = ST_INVALID;
				end else if (peer_closed) begin
					rsp.status = ST_CLOSED;
				end else if (!room) begin
					if (req.reliable_mode) begin
						rsp.status = ST_FULL;
					end else begin
						drops_d    = drops_q + 64'd1;
						rsp.status = ST_DROPPED;
					end
				end else if (req.action == ACT_PUBLISH) begin
					wr_req     = 1'b1;
					head_d     = head_q + 64'd1;
					rsp.notify = 1'b1;
				end else begin
					rsp.slot_index = 12'(head_idx);
				end
			end
			ACT_COMMIT: begin
				if (oversize) begin
					rsp.status = ST_INVALID;
				end else begin
					wr_req     = 1'b1;
					wr_addr    = tgt_idx;
					head_d     = head_q + 64'd1;
					rsp.notify = 1'b1;
				end
			end
			ACT_TAKE: begin
				if (head_q == req.read_cursor) begin
					rsp.status = ST_EMPTY;
				end else begin
					rsp.slot_index = 12'(cur_idx);
					if (meta.seq < req.read_cursor) begin
						rsp.status = ST_STALE;
					end else begin
						rsp.seq_number = meta.seq;
						rsp.slot_size  = meta.len;
						rsp.slot_time  = meta.stamp;
					end
				end
			end
			ACT_TAIL: begin
				tail_d = req.tail_value;
			end
			default: begin
			end
		endcase
		rsp.drop_count = drops_d;
	end

	assign wr_en = advance && wr_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			drops_q <= '0;
		end else if (advance) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			drops_q <= drops_d;
		end
	end

endmodule

`default_nettype wire

FILE: sv/loan_ring_descriptor_queue.sv
// ----------------------------------------------------------------------------
// loan_ring_descriptor_queue
// Single-producer, single-consumer descriptor ring with drop counter.
//
//   channel  | valid     | stall     | payload
//   ---------+-----------+-----------+------------------------
//   request  | req_valid | req_stall | req (lrdq_in_t)
//   response | rsp_valid | rsp_stall | rsp (lrdq_out_t)
//   config   | cfg_write_en (no stall) | cfg_index, cfg_data
//
// one request per cycle sustained while the response is not stalled; each
// response passes the request register, then the response register
// slot metadata read is issued at request transfer, written when it leaves
// the request register; a same-slot write at that edge is forwarded
// after reset a clearing pass zeroes all MAX_SLOTS slots of the slot memory,
// requests are stalled during it
// a stalled response holds; one more request is still taken behind it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module loan_ring_descriptor_queue import lrdq_pkg::*; #(
	parameter int unsigned MAX_SLOTS = DEF_MAX_SLOTS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire lrdq_in_t              req,
	output logic                       rsp_valid,
	input  wire logic                  rsp_stall,
	output lrdq_out_t                  rsp,
	input  wire logic                  cfg_write_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned IW = $clog2(MAX_SLOTS);
	localparam int unsigned NW = (IW + 1 > CFG_SLOT_W) ? IW + 1 : CFG_SLOT_W;
	localparam int unsigned MW = $bits(slot_meta_t);

	logic [CFG_SLOT_W-1:0] slot_count_q;
	logic [22:0]           payload_limit_q;
	logic                  peer_closed_q;

	logic [NW-1:0] n_clamp, n_smear;
	logic [IW-1:0] mask;

	logic          clearing_q;
	logic [IW-1:0] clr_addr_q;

	logic          accept, advance;
	logic          s1_valid_q;
	lrdq_in_t      req_s1;
	logic          byp_hit_s1;
	slot_meta_t    byp_data_s1;

	logic          rsp_valid_q;
	lrdq_out_t     rsp_q;
	lrdq_out_t     core_rsp;

	logic          core_wr_en;
	logic [IW-1:0] core_wr_addr;
	slot_meta_t    core_wr_data;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [MW-1:0] ram_wdata;
	logic [IW-1:0] ram_raddr;
	logic [MW-1:0] ram_rdata;
	slot_meta_t    meta;

	// live slot mask: clamp, then round down to a power of two
	always_comb begin
		n_clamp = NW'(slot_count_q);
		if (n_clamp < NW'(4)) begin
			n_clamp = NW'(4);
		end else if (n_clamp > NW'(MAX_SLOTS)) begin
			n_clamp = NW'(MAX_SLOTS);
		end
		n_smear = n_clamp;
		for (int i = 1; i < int'(NW); i++) begin
			n_smear = n_smear | (n_clamp >> i);
		end
	end

	assign mask = IW'(n_smear >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q    <= RST_SLOT_COUNT;
			payload_limit_q <= RST_PAYLOAD_LIMIT;
			peer_closed_q   <= 1'b0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_SLOT_COUNT:    slot_count_q    <= cfg_data[CFG_SLOT_W-1:0];
				CFG_PAYLOAD_LIMIT: payload_limit_q <= cfg_data;
				CFG_PEER_CLOSED:   peer_closed_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + IW'(1);
			if (clr_addr_q == IW'(MAX_SLOTS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// handshake
	assign advance   = s1_valid_q && (!rsp_valid_q || !rsp_stall);
	assign req_stall = clearing_q || (s1_valid_q && !advance);
	assign accept    = req_valid && !req_stall;

	assign ram_raddr = req.read_cursor[IW-1:0] & mask;
	assign ram_we    = clearing_q || core_wr_en;
	assign ram_waddr = clearing_q ? clr_addr_q : core_wr_addr;
	assign ram_wdata = clearing_q ? '0 : MW'(core_wr_data);

	lrdq_ram #(
		.WIDTH (MW),
		.DEPTH (MAX_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	// forward a write that lands on the read slot at the transfer edge
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1      <= req;
			byp_hit_s1  <= core_wr_en && (core_wr_addr == ram_raddr);
			byp_data_s1 <= core_wr_data;
		end
	end

	assign meta = byp_hit_s1 ? byp_data_s1 : slot_meta_t'(ram_rdata);

	lrdq_core #(
		.IW (IW)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_s1),
		.advance       (advance),
		.mask          (mask),
		.payload_limit (payload_limit_q),
		.peer_closed   (peer_closed_q),
		.meta          (meta),
		.rsp           (core_rsp),
		.wr_en         (core_wr_en),
		.wr_addr       (core_wr_addr),
		.wr_data       (core_wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= core_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

FILE: sv/lrdq_checker.sv
// ----------------------------------------------------------------------------
// lrdq_checker
// Port-level checks of the descriptor ring queue, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrdq_checker import lrdq_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      req_valid,
	input wire logic      req_stall,
	input wire logic      rsp_valid,
	input wire logic      rsp_stall,
	input wire lrdq_out_t rsp
);

`include "assert_macros.svh"

	logic empty_clean;

	assign empty_clean = rsp.seq_number == 64'd0 && rsp.slot_size == 23'd0 &&
		rsp.slot_time == 64'd0 && rsp.slot_index == 12'd0 && !rsp.notify;

	`LRDQ_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	`LRDQ_ASSERT_NOW(a_notify_ok, clk, arst_n, rsp_valid && rsp.notify, rsp.status == ST_OK)

	`LRDQ_ASSERT_NOW(a_status_range, clk, arst_n, rsp_valid, rsp.status <= ST_STALE)

	`LRDQ_ASSERT_NOW(a_empty_clean, clk, arst_n, rsp_valid && rsp.status == ST_EMPTY, empty_clean)

	`LRDQ_ASSERT_NEXT(a_stall_after_reset, clk, arst_n, $rose(arst_n), req_stall || !req_valid)

endmodule

bind loan_ring_descriptor_queue lrdq_checker u_lrdq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire

FILE: dv/loan_ring_descriptor_queue_test.sv
// ----------------------------------------------------------------------------
// loan_ring_descriptor_queue_test
// Self-checking bench for the descriptor ring. A scoreboard class keeps its
// own copy of the ring counters, slot metadata and registers. It computes the
// response due for every request transfer and matches it against the
// response transfers in order. A short directed part is followed by random
// phases. Each phase has its own register setting and a chosen mix of
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module loan_ring_descriptor_queue_test;
	import lrdq_pkg::*;

	localparam logic [2:0] ACT_SPARE = 3'd5;
	localparam logic [2:0] ACT_LAST  = 3'd7;

	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 88;
	localparam int unsigned PH_SLOTS [PHASES] = '{4, 4096, 5, 100, 8191, 8, 16, 256};
	localparam int unsigned PH_LIMIT [PHASES] =
		'{16, 4194304, 4194304, 16, 8388607, 1000, 4096, 4096};
	localparam int unsigned PH_CLOSED [PHASES] = '{0, 0, 0, 1, 0, 0, 0, 0};
	localparam int unsigned PH_GAP [PHASES]    = '{0, 85, 0, 32, 32, 85, 0, 0};
	localparam int unsigned PH_STALL [PHASES]  = '{0, 0, 85, 32, 32, 0, 85, 0};

	class ring_scoreboard;
		logic [12:0] slot_reg;
		logic [22:0] limit_reg;
		logic        closed_reg;
		logic [63:0] head;
		logic [63:0] tail;
		logic [63:0] drops;
		logic [63:0] seq_mem [DEF_MAX_SLOTS];
		logic [22:0] len_mem [DEF_MAX_SLOTS];
		logic [63:0] stamp_mem [DEF_MAX_SLOTS];
		lrdq_out_t   due [$];
		int          errors;

		function new();
			slot_reg = RST_SLOT_COUNT;
			limit_reg = RST_PAYLOAD_LIMIT;
			closed_reg = 1'b0;
			head = '0;
			tail = '0;
			drops = '0;
			errors = 0;
			foreach (seq_mem[i]) begin
				seq_mem[i] = '0;
				len_mem[i] = '0;
				stamp_mem[i] = '0;
			end
		endfunction

		// clamp to the legal range, then round down to a power of two
		function int unsigned ring_size();
			int unsigned lim;
			int unsigned p;
			lim = 32'(slot_reg);
			if (lim < 4) lim = 4;
			if (lim > DEF_MAX_SLOTS) lim = DEF_MAX_SLOTS;
			p = 4;
			while (p * 2 <= lim) p = p * 2;
			return p;
		endfunction

		function void store_slot(logic [11:0] idx, logic [22:0] len, logic [63:0] stamp);
			seq_mem[idx] = head;
			len_mem[idx] = len;
			stamp_mem[idx] = stamp;
			head = head + 64'd1;
		endfunction

		function void note_request(lrdq_in_t r);
			lrdq_out_t   e;
			int unsigned n;
			logic [11:0] msk;
			logic [11:0] idx;
			logic [63:0] used;
			n = ring_size();
			msk = 12'(n - 1);
			used = head - tail;
			e = '0;
			case (r.action)
				ACT_PUBLISH, ACT_BORROW: begin
					if (r.action == ACT_PUBLISH && r.data_len > limit_reg) begin
						e.status = ST_INVALID;
					end else if (closed_reg) begin
						e.status = ST_CLOSED;
					end else if (used > 64'(n - 2)) begin
						if (r.reliable_mode) begin
							e.status = ST_FULL;
						end else begin
							drops = drops + 64'd1;
							e.status = ST_DROPPED;
						end
					end else if (r.action == ACT_PUBLISH) begin
						store_slot(head[11:0] & msk, r.data_len, r.stamp_time);
						e.notify = 1'b1;
					end else begin
						e.slot_index = head[11:0] & msk;
					end
				end
				ACT_COMMIT: begin
					if (r.data_len > limit_reg) begin
						e.status = ST_INVALID;
					end else begin
						store_slot(r.target_slot & msk, r.data_len, r.stamp_time);
						e.notify = 1'b1;
					end
				end
				ACT_TAKE: begin
					if (head == r.read_cursor) begin
						e.status = ST_EMPTY;
					end else begin
						idx = r.read_cursor[11:0] & msk;
						e.slot_index = idx;
						if (seq_mem[idx] < r.read_cursor) begin
							e.status = ST_STALE;
						end else begin
							e.seq_number = seq_mem[idx];
							e.slot_size = len_mem[idx];
							e.slot_time = stamp_mem[idx];
						end
					end
				end
				ACT_TAIL: begin
					tail = r.tail_value;
				end
				default: begin
				end
			endcase
			e.drop_count = drops;
			due.push_back(e);
		endfunction

		function void field_check(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t ns: %s expected %h got %h", $time, name, want, got);
			end
		endfunction

		function void check_response(lrdq_out_t got);
			lrdq_out_t e;
			if (due.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected response, expected none got %h", $time, got);
				return;
			end
			e = due.pop_front();
			field_check("status", 64'(e.status), 64'(got.status));
			field_check("slot_index", 64'(e.slot_index), 64'(got.slot_index));
			field_check("seq_number", e.seq_number, got.seq_number);
			field_check("slot_size", 64'(e.slot_size), 64'(got.slot_size));
			field_check("slot_time", e.slot_time, got.slot_time);
			field_check("drop_count", e.drop_count, got.drop_count);
			field_check("notify", 64'(e.notify), 64'(got.notify));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	lrdq_in_t              req = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	lrdq_out_t             rsp;
	logic                  cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int unsigned    gap_pct = 0;
	int unsigned    stall_pct = 0;
	ring_scoreboard sb;

	loan_ring_descriptor_queue uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("** loan_ring_descriptor_queue: FAILED **");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) sb.check_response(rsp);
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic lrdq_in_t make_req(logic [2:0] act, logic [22:0] size, logic rel,
			logic [63:0] stamp, logic [11:0] tgt, logic [63:0] cur, logic [63:0] tl);
		lrdq_in_t r;
		r.action = act;
		r.data_len = size;
		r.reliable_mode = rel;
		r.stamp_time = stamp;
		r.target_slot = tgt;
		r.read_cursor = cur;
		r.tail_value = tl;
		return r;
	endfunction

	// mixed producer and consumer traffic around the current head, some noise
	function automatic lrdq_in_t next_request();
		lrdq_in_t    r;
		int unsigned n;
		int unsigned lim;
		int unsigned pick;
		logic [11:0] msk;
		logic [63:0] h;
		n = sb.ring_size();
		lim = 32'(sb.limit_reg);
		msk = 12'(n - 1);
		h = sb.head;
		r.data_len = 23'($urandom);
		r.reliable_mode = 1'($urandom);
		r.stamp_time = {$urandom, $urandom};
		r.target_slot = 12'($urandom);
		r.read_cursor = {$urandom, $urandom};
		r.tail_value = {$urandom, $urandom};
		pick = $urandom_range(99);
		if (pick < 24) r.action = ACT_PUBLISH;
		else if (pick < 36) r.action = ACT_BORROW;
		else if (pick < 52) r.action = ACT_COMMIT;
		else if (pick < 76) r.action = ACT_TAKE;
		else if (pick < 92) r.action = ACT_TAIL;
		else if (pick < 97) r.action = 3'($urandom_range(ACT_SPARE, ACT_LAST));
		else r.action = 3'($urandom);
		case ($urandom_range(9))
			0: begin
			end
			1: r.data_len = 23'(lim);
			2: r.data_len = 23'(lim + 1);
			default: r.data_len = 23'($urandom_range(0, lim));
		endcase
		if ($urandom_range(99) < 80) r.target_slot = h[11:0] & msk;
		if ($urandom_range(99) < 85) r.read_cursor = h - 64'($urandom_range(0, n + 1));
		pick = $urandom_range(99);
		if (pick < 80) r.tail_value = h - 64'($urandom_range(0, n));
		else if (pick < 90) r.tail_value = h + 64'($urandom_range(1, 3));
		return r;
	endfunction

	task automatic send_request(input lrdq_in_t r);
		while ($urandom_range(99) < gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		sb.note_request(r);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic [22:0] slots, input logic [22:0] lim,
			input logic closed);
		drain();
		cfg_write_en <= 1'b1;
		cfg_index <= CFG_SLOT_COUNT;
		cfg_data <= slots;
		@(posedge clk);
		cfg_index <= CFG_PAYLOAD_LIMIT;
		cfg_data <= lim;
		@(posedge clk);
		cfg_index <= CFG_PEER_CLOSED;
		cfg_data <= {22'd0, closed};
		@(posedge clk);
		cfg_write_en <= 1'b0;
		sb.slot_reg = slots[12:0];
		sb.limit_reg = lim;
		sb.closed_reg = closed;
	endtask

	initial begin
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// default registers: empty ring, unwritten slot, limits, full ring
		send_request(make_req(ACT_TAKE, 23'd0, 1'b0, 64'd0, 12'd0, 64'd0, 64'd0));
		send_request(make_req(ACT_COMMIT, 23'd16, 1'b0, 64'h0123_4567_89ab_cdef, 12'd7,
			64'd0, 64'd0));
		send_request(make_req(ACT_TAKE, 23'd0, 1'b0, 64'd0, 12'd0, 64'd0, 64'd0));
		send_request(make_req(ACT_PUBLISH, 23'd4096, 1'b1, '1, 12'd0, 64'd0, 64'd0));
		send_request(make_req(ACT_PUBLISH, 23'd4097, 1'b0, 64'd5, 12'd0, 64'd0, 64'd0));
		send_request(make_req(ACT_PUBLISH, '1, 1'b1, 64'd6, 12'd0, 64'd0, 64'd0));
		send_request(make_req(ACT_BORROW, '1, 1'b1, 64'd0, 12'd0, 64'd0, 64'd0));
		send_request(make_req(ACT_COMMIT, 23'd0, 1'b0, 64'd0, '1, 64'd0, 64'd0));
		send_request(make_req(ACT_TAKE, 23'd0, 1'b0, 64'd0, 12'd0, 64'd1, 64'd0));
		send_request(make_req(ACT_TAKE, 23'd0, 1'b0, 64'd0, 12'd0, 64'd255, 64'd0));
		send_request(make_req(ACT_TAKE, 23'd0, 1'b0, 64'd0, 12'd0, 64'd3, 64'd0));
		send_request(make_req(ACT_TAKE, 23'd0, 1'b0, 64'd0, 12'd0, '1, 64'd0));
		send_request(make_req(ACT_TAIL, 23'd0, 1'b0, 64'd0, 12'd0, 64'd0, '1));
		send_request(make_req(ACT_TAIL, 23'd0, 1'b0, 64'd0, 12'd0, 64'd0, 64'd4));
		send_request(make_req(ACT_PUBLISH, 23'd8, 1'b1, 64'd9, 12'd0, 64'd0, 64'd0));
		send_request(make_req(ACT_PUBLISH, 23'd8, 1'b0, 64'd9, 12'd0, 64'd0, 64'd0));
		send_request(make_req(ACT_BORROW, 23'd0, 1'b0, 64'd0, 12'd0, 64'd0, 64'd0));
		send_request(make_req(ACT_BORROW, 23'd0, 1'b1, 64'd0, 12'd0, 64'd0, 64'd0));
		send_request(make_req(ACT_COMMIT, 23'd100, 1'b0, 64'd77, 12'd5, 64'd0, 64'd0));
		send_request(make_req(ACT_SPARE, '1, 1'b1, '1, '1, '1, '1));
		send_request(make_req(ACT_LAST, '1, 1'b1, '1, '1, '1, '1));
		send_request(make_req(ACT_TAIL, 23'd0, 1'b0, 64'd0, 12'd0, 64'd0, 64'd0));

		// torn-down ring: size test first, commit still goes through
		configure(23'(RST_SLOT_COUNT), RST_PAYLOAD_LIMIT, 1'b1);
		send_request(make_req(ACT_PUBLISH, 23'd4097, 1'b0, 64'd1, 12'd0, 64'd0, 64'd0));
		send_request(make_req(ACT_PUBLISH, 23'd10, 1'b0, 64'd2, 12'd0, 64'd0, 64'd0));
		send_request(make_req(ACT_BORROW, 23'd10, 1'b0, 64'd3, 12'd0, 64'd0, 64'd0));
		send_request(make_req(ACT_COMMIT, 23'd4096, 1'b1, 64'd4, 12'd1, 64'd0, 64'd0));

		for (int p = 0; p < PHASES; p++) begin
			configure(23'(PH_SLOTS[p]), 23'(PH_LIMIT[p]), PH_CLOSED[p][0]);
			gap_pct = PH_GAP[p];
			stall_pct = PH_STALL[p];
			repeat (PHASE_ITEMS) send_request(next_request());
		end

		req_valid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.due.size() == 0) begin
			$display("** loan_ring_descriptor_queue: PASSED **");
		end else begin
			$display("** loan_ring_descriptor_queue: FAILED **");
		end
		$finish;
	end

endmodule
